// ===== sv/aatc_pkg.sv =====
// ----------------------------------------------------------------------------
// aatc_pkg
// Shared constants for the averaged ADC / thermistor conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package aatc_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF      = 32;
  localparam int unsigned AVERAGED_CHANNELS_DEF = 3;
  localparam int unsigned SAMPLE_BITS_DEF       = 10;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TEMP     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PRESSURE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_VALUE      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_RESISTANCE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_KELVIN      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET = 4'd7;

  localparam logic [1:0] CH_PRESSURE = 2'd2;
  localparam logic [1:0] CH_THROTTLE = 2'd3;

  localparam int unsigned MV_W   = 12;
  localparam logic [MV_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam int unsigned R_W    = 28;
  localparam int unsigned Q_BITS = 16;
  localparam int unsigned X_W    = R_W + Q_BITS;
  localparam int unsigned Y_W    = 21;
  localparam int unsigned LN2_W  = 31;
  localparam logic [LN2_W-1:0] LN2_Q31 = 31'h58B90BFC;
  localparam int unsigned PROD_W = Y_W + LN2_W;

  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DVS_W = 34;
  localparam int unsigned DEN_W     = DIV_DVS_W + 1;

endpackage

`default_nettype wire

// ===== sv/aatc_ram.sv =====
// ----------------------------------------------------------------------------
// aatc_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aatc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/adc_average_thermistor_convert.sv =====
// ----------------------------------------------------------------------------
// adc_average_thermistor_convert
// Windowed average of ADC samples per channel, NTC beta conversion to Kelvin,
// linear pressure scaling and throttle percentage.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample, tuser: channel
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: value, tuser: channel, invalid
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  One item at a time. Throttle: scaled to percent on acceptance. Averaged
//  channels: a read-modify-write pass over the window in the sample RAM,
//  then a 32-step shared divider per division (2 for pressure, 4 for
//  temperature) and, for temperature, two Q16 logs.
//  After reset a clearing pass zeroes every word of the sample RAM; no
//  input is taken meanwhile. A finished result waits in the output register
//  while the next input is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_thermistor_convert
  import aatc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH      = WINDOW_DEPTH_DEF,
  parameter int unsigned AVERAGED_CHANNELS = AVERAGED_CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample
  input  logic [1:0]                            s_axis_tuser,   // channel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [15:0]                           m_axis_tdata,   // value
  output logic [2:0]                            m_axis_tuser,   // result_channel, invalid
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_data_i
);

  localparam int unsigned STORE_CH  = (AVERAGED_CHANNELS < 3) ? 3 : AVERAGED_CHANNELS;
  localparam int unsigned MEM_DEPTH = STORE_CH * WINDOW_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned NW        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W     = SAMPLE_BITS + NW;
  localparam int unsigned MVP_W     = SAMPLE_BITS + MV_W;
  localparam int unsigned TH_W      = SAMPLE_BITS + 7;
  localparam int unsigned PRS_W     = 25;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SHIFT, S_MEAN, S_MV, S_PRS_DIV, S_R_DIV,
    S_LN_R, S_LN_REF, S_BK_DIV, S_DEN, S_K_DIV, S_DONE
  } state_e;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_OUT} ln_phase_e;

  // configuration
  logic [5:0]  win_temp_q, win_prs_q;
  logic [15:0] beta_q, series_q;
  logic [19:0] rref_q;
  logic [9:0]  rk_q;
  logic [11:0] gain_q, offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_temp_q <= 6'd32;
      win_prs_q  <= 6'd5;
      beta_q     <= 16'd3520;
      rref_q     <= 20'd1880;
      rk_q       <= 10'd300;
      series_q   <= 16'd1000;
      gain_q     <= 12'd466;
      offset_q   <= 12'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WINDOW_TEMP:     win_temp_q <= cfg_data_i[5:0];
        REG_WINDOW_PRESSURE: win_prs_q  <= cfg_data_i[5:0];
        REG_BETA_VALUE:      beta_q     <= cfg_data_i[15:0];
        REG_REF_RESISTANCE:  rref_q     <= cfg_data_i[19:0];
        REG_REF_KELVIN:      rk_q       <= cfg_data_i[9:0];
        REG_SERIES_RES:      series_q   <= cfg_data_i[15:0];
        REG_PRESSURE_GAIN:   gain_q     <= cfg_data_i[11:0];
        REG_PRESSURE_OFFSET: offset_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // main control
  state_e                  state_q;
  logic [AW-1:0]           clr_q;
  logic [1:0]              ch_q;
  logic [SAMPLE_BITS-1:0]  smp_q;
  logic [NW-1:0]           n_q, k_q;
  logic [SUM_W-1:0]        sum_q;
  logic [MV_W-1:0]         mv_q;
  logic [Y_W-1:0]          lnr_q, lnref_q;
  logic [DIV_NUM_W-1:0]    bqk_q;
  logic [15:0]             res_val_q;
  logic                    res_inv_q;
  logic                    m_valid_q;
  logic [15:0]             m_data_q;
  logic [2:0]              m_user_q;

  // shared divider
  logic                    div_start_q, div_busy_q, div_done_q;
  logic [DIV_NUM_W-1:0]    div_num_q, div_quo_q;
  logic [DIV_DVS_W-1:0]    div_dvs_q, div_rem_q;
  logic [5:0]              div_cnt_q;

  // log unit
  logic                    ln_start_q, ln_done_q;
  logic [R_W-1:0]          ln_in_q;
  ln_phase_e               ln_phase_q;
  logic [X_W-1:0]          ln_x_q;
  logic [4:0]              ln_yi_q;
  logic [Q_BITS-1:0]       ln_fr_q;
  logic [3:0]              ln_cnt_q;
  logic [PROD_W-1:0]       ln_prod_q;
  logic [Y_W-1:0]          ln_res_q;

  // sample RAM
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr, base_in, base_q;
  logic [SAMPLE_BITS-1:0]  ram_wdata, ram_rdata;

  logic [SAMPLE_BITS-1:0]  s_in, win_val;
  logic [5:0]              win_in;
  logic [NW-1:0]           n_in;
  logic                    in_acc;
  logic [DIV_NUM_W-1:0]    bq;
  logic [DEN_W-1:0]        den;

  assign s_in    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign base_in = AW'(32'(s_axis_tuser) * WINDOW_DEPTH);
  assign base_q  = AW'(32'(ch_q) * WINDOW_DEPTH);
  assign win_in  = (s_axis_tuser == CH_PRESSURE) ? win_prs_q : win_temp_q;
  assign n_in    = (win_in == 6'd0) ? NW'(1) :
                   (32'(win_in) > WINDOW_DEPTH) ? NW'(WINDOW_DEPTH) : NW'(win_in);
  assign win_val = (NW'(k_q + NW'(1)) < n_q) ? ram_rdata : smp_q;
  assign bq      = {beta_q, 16'd0};
  assign den     = DEN_W'(bqk_q) + DEN_W'(lnr_q) - DEN_W'(lnref_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(base_q + AW'(k_q));
    ram_wdata = win_val;
    ram_raddr = AW'(base_in + AW'(1));
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_SHIFT) begin
      ram_we    = 1'b1;
      ram_raddr = AW'(base_q + AW'(k_q) + AW'(2));
    end
  end

  aatc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      m_valid_q   <= 1'b0;
      div_start_q <= 1'b0;
      ln_start_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      ln_start_q  <= 1'b0;
      if (m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= AW'(clr_q + AW'(1));
          if (32'(clr_q) == MEM_DEPTH - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            ch_q  <= s_axis_tuser;
            smp_q <= s_in;
            n_q   <= n_in;
            k_q   <= '0;
            sum_q <= '0;
            if (s_axis_tuser == CH_THROTTLE) begin
              res_val_q <= 16'((TH_W'(s_in) * TH_W'(100)) >> SAMPLE_BITS);
              res_inv_q <= 1'b0;
              state_q   <= S_DONE;
            end else begin
              state_q <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          sum_q <= SUM_W'(sum_q + SUM_W'(win_val));
          if (k_q == NW'(n_q - NW'(1))) begin
            div_num_q   <= DIV_NUM_W'(SUM_W'(sum_q + SUM_W'(win_val)));
            div_dvs_q   <= DIV_DVS_W'(n_q);
            div_start_q <= 1'b1;
            state_q     <= S_MEAN;
          end else begin
            k_q <= NW'(k_q + NW'(1));
          end
        end
        S_MEAN: begin
          if (div_done_q) begin
            mv_q <= MV_W'((MVP_W'(div_quo_q[SAMPLE_BITS-1:0]) * MVP_W'(FULL_SCALE_MV))
                          >> SAMPLE_BITS);
            state_q <= S_MV;
          end
        end
        S_MV: begin
          if (ch_q == CH_PRESSURE) begin
            div_num_q   <= DIV_NUM_W'(PRS_W'(mv_q) * PRS_W'(gain_q) + PRS_W'(500));
            div_dvs_q   <= DIV_DVS_W'(1000);
            div_start_q <= 1'b1;
            state_q     <= S_PRS_DIV;
          end else if (mv_q >= FULL_SCALE_MV) begin
            res_val_q <= '0;
            res_inv_q <= 1'b1;
            state_q   <= S_DONE;
          end else begin
            div_num_q   <= DIV_NUM_W'(R_W'(mv_q) * R_W'(series_q));
            div_dvs_q   <= DIV_DVS_W'(MV_W'(FULL_SCALE_MV - mv_q));
            div_start_q <= 1'b1;
            state_q     <= S_R_DIV;
          end
        end
        S_PRS_DIV: begin
          if (div_done_q) begin
            res_val_q <= (33'(div_quo_q) + 33'(offset_q) > 33'd65535) ? 16'hFFFF :
                         16'(div_quo_q + 32'(offset_q));
            res_inv_q <= 1'b0;
            state_q   <= S_DONE;
          end
        end
        S_R_DIV: begin
          if (div_done_q) begin
            if (div_quo_q == '0 || rref_q == '0 || rk_q == '0) begin
              res_val_q <= '0;
              res_inv_q <= 1'b1;
              state_q   <= S_DONE;
            end else begin
              ln_in_q    <= div_quo_q[R_W-1:0];
              ln_start_q <= 1'b1;
              state_q    <= S_LN_R;
            end
          end
        end
        S_LN_R: begin
          if (ln_done_q) begin
            lnr_q      <= ln_res_q;
            ln_in_q    <= R_W'(rref_q);
            ln_start_q <= 1'b1;
            state_q    <= S_LN_REF;
          end
        end
        S_LN_REF: begin
          if (ln_done_q) begin
            lnref_q     <= ln_res_q;
            div_num_q   <= bq;
            div_dvs_q   <= DIV_DVS_W'(rk_q);
            div_start_q <= 1'b1;
            state_q     <= S_BK_DIV;
          end
        end
        S_BK_DIV: begin
          if (div_done_q) begin
            bqk_q   <= div_quo_q;
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          if (den[DEN_W-1] || den == '0) begin
            res_val_q <= '0;
            res_inv_q <= 1'b1;
            state_q   <= S_DONE;
          end else begin
            div_num_q   <= bq;
            div_dvs_q   <= den[DIV_DVS_W-1:0];
            div_start_q <= 1'b1;
            state_q     <= S_K_DIV;
          end
        end
        S_K_DIV: begin
          if (div_done_q) begin
            res_val_q <= (div_quo_q > 32'd65535) ? 16'hFFFF : div_quo_q[15:0];
            res_inv_q <= 1'b0;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_val_q;
            m_user_q  <= {res_inv_q, ch_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // restoring divider, one quotient bit per cycle
  logic [DIV_DVS_W:0] div_sh, div_diff;
  logic               div_ge;

  assign div_sh   = {div_rem_q, div_quo_q[DIV_NUM_W-1]};
  assign div_ge   = div_sh >= {1'b0, div_dvs_q};
  assign div_diff = div_sh - {1'b0, div_dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (div_start_q) begin
        div_busy_q <= 1'b1;
        div_rem_q  <= '0;
        div_quo_q  <= div_num_q;
        div_cnt_q  <= 6'(DIV_NUM_W);
      end else if (div_busy_q) begin
        div_rem_q <= div_ge ? div_diff[DIV_DVS_W-1:0] : div_sh[DIV_DVS_W-1:0];
        div_quo_q <= {div_quo_q[DIV_NUM_W-2:0], div_ge};
        div_cnt_q <= 6'(div_cnt_q - 6'd1);
        if (div_cnt_q == 6'd1) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  // Q16 natural log: normalize, 16 squaring steps, scale by ln2
  logic [2*(Q_BITS+1)-1:0] ln_sq;
  logic [Q_BITS+1:0]       ln_zs;

  assign ln_sq = ln_x_q[Q_BITS:0] * ln_x_q[Q_BITS:0];
  assign ln_zs = ln_sq[2*(Q_BITS+1)-1:Q_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_phase_q <= L_IDLE;
      ln_done_q  <= 1'b0;
    end else begin
      ln_done_q <= 1'b0;
      case (ln_phase_q)
        L_IDLE: begin
          if (ln_start_q) begin
            ln_x_q     <= {ln_in_q, Q_BITS'(0)};
            ln_yi_q    <= '0;
            ln_cnt_q   <= '0;
            ln_phase_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (ln_x_q[X_W-1:Q_BITS+1] != '0) begin
            ln_x_q  <= ln_x_q >> 1;
            ln_yi_q <= 5'(ln_yi_q + 5'd1);
          end else begin
            ln_phase_q <= L_SQ;
          end
        end
        L_SQ: begin
          ln_x_q  <= X_W'(ln_zs[Q_BITS+1] ? ln_zs[Q_BITS+1:1] : ln_zs[Q_BITS:0]);
          ln_fr_q <= {ln_fr_q[Q_BITS-2:0], ln_zs[Q_BITS+1]};
          ln_cnt_q <= 4'(ln_cnt_q + 4'd1);
          if (ln_cnt_q == 4'(Q_BITS - 1)) begin
            ln_phase_q <= L_MUL;
          end
        end
        L_MUL: begin
          ln_prod_q  <= PROD_W'({ln_yi_q, ln_fr_q}) * PROD_W'(LN2_Q31);
          ln_phase_q <= L_OUT;
        end
        L_OUT: begin
          ln_res_q   <= ln_prod_q[PROD_W-1:LN2_W];
          ln_done_q  <= 1'b1;
          ln_phase_q <= L_IDLE;
        end
        default: ln_phase_q <= L_IDLE;
      endcase
    end
  end

  // checks
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy_q)
    else $error("divider restarted while busy");

  a_ln_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_start_q |-> ln_phase_q == L_IDLE)
    else $error("log unit restarted while busy");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> ram_waddr != ram_raddr)
    else $error("window write collides with pending read");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && m_valid_q && !m_axis_tready |=> state_q == S_DONE)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
